>>> sv/crcp_pkg.sv
// ----------------------------------------------------------------------------
// crcp_pkg: shared types and constants
// Record kinds, status codes, parse phases and the byte-wise CRC-16 step.
// ----------------------------------------------------------------------------
`default_nettype none
package crcp_pkg;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam int unsigned HeaderBytes  = 10;
  localparam int unsigned StepHdrBytes = 8;
  localparam int unsigned MinFileBytes = 14;

  typedef enum logic [1:0] {
    KIND_STEP   = 2'd0,
    KIND_PARAM  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SMALL     = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_CRC       = 3'd3,
    ST_STEP_LEN  = 3'd4,
    ST_STEP_MAG  = 3'd5,
    ST_STEP_OVF  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_STEPHDR = 2'd1,
    PH_PARAMS  = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REG_HDR_MAGIC  = 2'd0,
    REG_STEP_MAGIC = 2'd1,
    REG_MAX_STEPS  = 2'd2
  } reg_e;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       parse;
    logic       eof;
    logic       short_file;
    logic [15:0] eof_crc;
  } job_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [15:0] step_number;
    logic [15:0] step_ident;
    logic [7:0]  action_code;
    logic [7:0]  param_length;
    logic [7:0]  param_position;
    logic [7:0]  param_value;
    logic [2:0]  parse_status;
    logic        last_of_run;
  } rec_t;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> sv/crcp_if.sv
// ----------------------------------------------------------------------------
// crcp_if: valid/ready channel interfaces
// Input byte channel, configuration write channel and record output channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface crcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  modport source (output valid, data_byte, end_of_file, input ready);
  modport sink (input valid, data_byte, end_of_file, output ready);
endinterface

interface crcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface crcp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [15:0] step_number;
  logic [15:0] step_ident;
  logic [7:0]  action_code;
  logic [7:0]  param_length;
  logic [7:0]  param_position;
  logic [7:0]  param_value;
  logic [2:0]  parse_status;
  logic        last_of_run;
  modport source (output valid, record_kind, step_number, step_ident, action_code,
                  param_length, param_position, param_value, parse_status,
                  last_of_run, input ready);
  modport sink (input valid, record_kind, step_number, step_ident, action_code,
                param_length, param_position, param_value, parse_status,
                last_of_run, output ready);
endinterface
`default_nettype wire

>>> sv/crcp_front.sv
// ----------------------------------------------------------------------------
// crcp_front: delay line and size counter
// Holds each byte back two places and tags it with the end-of-file facts.
// ----------------------------------------------------------------------------
`default_nettype none
module crcp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      in_data_i,
  input  wire logic            in_eof_i,
  output      logic            in_ready_o,
  output      logic            job_valid_o,
  output      crcp_pkg::job_t  job_o,
  input  wire logic            job_ready_i
);

  logic [31:0] count_q;
  logic [7:0]  d0_q, d1_q;
  logic        acc;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign acc         = in_valid_i && job_ready_i;

  always_comb begin
    job_o.data       = d0_q;
    job_o.parse      = (count_q >= 32'd2);
    job_o.eof        = in_eof_i;
    job_o.short_file = (count_q < 32'(crcp_pkg::MinFileBytes - 1));
    job_o.eof_crc    = {in_data_i, d1_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      d0_q    <= '0;
      d1_q    <= '0;
    end else if (acc) begin
      if (in_eof_i) begin
        count_q <= '0;
        d0_q    <= '0;
        d1_q    <= '0;
      end else begin
        if (count_q != 32'hFFFF_FFFF) count_q <= count_q + 32'd1;
        d0_q <= d1_q;
        d1_q <= in_data_i;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/crcp_fifo.sv
// ----------------------------------------------------------------------------
// crcp_fifo: two-entry job queue
// Decouples the front from the back so that each may stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none
module crcp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  input  wire crcp_pkg::job_t wr_job_i,
  output      logic           wr_ready_o,
  output      logic           rd_valid_o,
  output      crcp_pkg::job_t rd_job_o,
  input  wire logic           rd_ready_i
);

  crcp_pkg::job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_job_o   = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
`default_nettype wire

>>> sv/crcp_back.sv
// ----------------------------------------------------------------------------
// crcp_back: header and step parser
// Folds each byte into the CRC, parses fields and emits records.
// ----------------------------------------------------------------------------
`default_nettype none
module crcp_back #(
  parameter int unsigned MaxParamBytes = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  wire crcp_pkg::job_t job_i,
  output      logic           job_ready_o,
  input  wire logic [31:0]    hdr_magic_i,
  input  wire logic [31:0]    step_magic_i,
  input  wire logic [15:0]    max_steps_i,
  output      logic           rec_valid_o,
  output      crcp_pkg::rec_t rec_o,
  input  wire logic           rec_ready_i
);

  crcp_pkg::phase_e phase_q, phase_d;
  logic [31:0] hmagic_q, hmagic_d;
  logic [15:0] hcount_q, hcount_d, hcrcf_q, hcrcf_d;
  logic [15:0] crc_q, crc_d, hcrc_q, hcrc_d, steps_q, steps_d;
  logic [7:0]  fc_q, fc_d;
  logic [31:0] smagic_q, smagic_d;
  logic [15:0] sid_q, sid_d;
  logic [7:0]  act_q, act_d, plen_q, plen_d;
  logic [2:0]  err_q, err_d;

  // two-slot output buffer; slot 0 is head
  crcp_pkg::rec_t obuf_q [2];
  logic [1:0]  ocnt_q;
  logic        take, pop;
  crcp_pkg::rec_t r0, r1;
  logic        e0, e1;
  logic [15:0] crc_n;
  logic [15:0] steps_n;
  logic [2:0]  st;
  logic        hdr_ok;

  assign rec_valid_o = (ocnt_q != 2'd0);
  assign rec_o       = obuf_q[0];
  assign pop         = rec_valid_o && rec_ready_i;
  assign job_ready_o = (ocnt_q == 2'd0) || (ocnt_q == 2'd1 && rec_ready_i);
  assign take        = job_valid_i && job_ready_o;
  assign crc_n       = crcp_pkg::crc_step(crc_q, job_i.data);

  always_comb begin
    phase_d = phase_q; hmagic_d = hmagic_q; hcount_d = hcount_q; hcrcf_d = hcrcf_q;
    crc_d = crc_q; hcrc_d = hcrc_q; steps_d = steps_q; fc_d = fc_q;
    smagic_d = smagic_q; sid_d = sid_q; act_d = act_q; plen_d = plen_q; err_d = err_q;
    e0 = 1'b0; e1 = 1'b0; r0 = '0; r1 = '0; st = crcp_pkg::ST_OK; hdr_ok = 1'b0;
    steps_n = steps_q + 16'd1;
    if (job_i.parse) begin
      crc_d = crc_n;
      case (phase_q)
        crcp_pkg::PH_HEADER: begin
          case (fc_q[3:0])
            4'd0: hmagic_d[7:0]   = job_i.data;
            4'd1: hmagic_d[15:8]  = job_i.data;
            4'd2: hmagic_d[23:16] = job_i.data;
            4'd3: hmagic_d[31:24] = job_i.data;
            4'd6: hcount_d[7:0]   = job_i.data;
            4'd7: begin
              hcount_d[15:8] = job_i.data;
              hcrc_d = crc_n;
            end
            4'd8: hcrcf_d[7:0]   = job_i.data;
            4'd9: hcrcf_d[15:8]  = job_i.data;
            default: ;
          endcase
          fc_d = fc_q + 8'd1;
          if (fc_q == 8'(crcp_pkg::HeaderBytes - 1)) begin
            hdr_ok = (hmagic_q == hdr_magic_i) && (hcount_q <= max_steps_i)
                     && ({job_i.data, hcrcf_q[7:0]} == hcrc_q);
            fc_d = '0;
            phase_d = (!hdr_ok || hcount_q == 16'd0) ? crcp_pkg::PH_DONE
                                                     : crcp_pkg::PH_STEPHDR;
          end
        end
        crcp_pkg::PH_STEPHDR: begin
          case (fc_q[2:0])
            3'd0: smagic_d[7:0]   = job_i.data;
            3'd1: smagic_d[15:8]  = job_i.data;
            3'd2: smagic_d[23:16] = job_i.data;
            3'd3: smagic_d[31:24] = job_i.data;
            3'd4: sid_d[7:0]      = job_i.data;
            3'd5: sid_d[15:8]     = job_i.data;
            3'd6: act_d           = job_i.data;
            default: plen_d       = job_i.data;
          endcase
          fc_d = fc_q + 8'd1;
          if (fc_q == 8'(crcp_pkg::StepHdrBytes - 1)) begin
            fc_d = '0;
            if (smagic_q != step_magic_i) begin
              err_d = crcp_pkg::ST_STEP_MAG; phase_d = crcp_pkg::PH_DONE;
            end else if (job_i.data > 8'(MaxParamBytes)) begin
              err_d = crcp_pkg::ST_STEP_OVF; phase_d = crcp_pkg::PH_DONE;
            end else begin
              e0 = 1'b1;
              r0.record_kind = crcp_pkg::KIND_STEP;
              r0.step_number = steps_q; r0.step_ident = sid_q;
              r0.action_code = act_q; r0.param_length = job_i.data;
              if (job_i.data == 8'd0) begin
                steps_d = steps_n;
                phase_d = (steps_n >= hcount_q) ? crcp_pkg::PH_DONE : crcp_pkg::PH_STEPHDR;
              end else begin
                phase_d = crcp_pkg::PH_PARAMS;
              end
            end
          end
        end
        crcp_pkg::PH_PARAMS: begin
          e0 = 1'b1;
          r0.record_kind = crcp_pkg::KIND_PARAM;
          r0.step_number = steps_q; r0.step_ident = sid_q;
          r0.action_code = act_q; r0.param_length = plen_q;
          r0.param_position = fc_q; r0.param_value = job_i.data;
          fc_d = fc_q + 8'd1;
          if (fc_d >= plen_q) begin
            steps_d = steps_n; fc_d = '0;
            phase_d = (steps_n >= hcount_q) ? crcp_pkg::PH_DONE : crcp_pkg::PH_STEPHDR;
          end
        end
        default: ;
      endcase
    end
    if (job_i.eof) begin
      if (job_i.short_file)                st = crcp_pkg::ST_SMALL;
      else if (hmagic_d != hdr_magic_i)    st = crcp_pkg::ST_MAGIC;
      else if (hcount_d > max_steps_i)     st = crcp_pkg::ST_CRC;
      else if (hcrcf_d != hcrc_d)          st = crcp_pkg::ST_CRC;
      else if (job_i.eof_crc != crc_d)     st = crcp_pkg::ST_CRC;
      else if (err_d != 3'd0)              st = err_d;
      else if (phase_d == crcp_pkg::PH_STEPHDR) st = crcp_pkg::ST_STEP_LEN;
      else if (phase_d == crcp_pkg::PH_PARAMS)  st = crcp_pkg::ST_STEP_OVF;
      else                                 st = crcp_pkg::ST_OK;
      e1 = 1'b1;
      r1.record_kind = crcp_pkg::KIND_STATUS;
      r1.step_number = steps_d;
      r1.parse_status = st;
      r1.last_of_run = 1'b1;
      phase_d = crcp_pkg::PH_HEADER; hmagic_d = '0; hcount_d = '0; hcrcf_d = '0;
      crc_d = '0; hcrc_d = '0; steps_d = '0; fc_d = '0; smagic_d = '0;
      sid_d = '0; act_d = '0; plen_d = '0; err_d = '0;
    end else begin
      r0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= crcp_pkg::PH_HEADER;
      hmagic_q <= '0; hcount_q <= '0; hcrcf_q <= '0; crc_q <= '0; hcrc_q <= '0;
      steps_q <= '0; fc_q <= '0; smagic_q <= '0; sid_q <= '0; act_q <= '0;
      plen_q <= '0; err_q <= '0; ocnt_q <= '0;
    end else begin
      if (take) begin
        phase_q <= phase_d; hmagic_q <= hmagic_d; hcount_q <= hcount_d;
        hcrcf_q <= hcrcf_d; crc_q <= crc_d; hcrc_q <= hcrc_d; steps_q <= steps_d;
        fc_q <= fc_d; smagic_q <= smagic_d; sid_q <= sid_d; act_q <= act_d;
        plen_q <= plen_d; err_q <= err_d;
      end
      ocnt_q <= ocnt_q - {1'b0, pop} + {1'b0, take && e0} + {1'b0, take && e1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && (e0 || e1)) begin
      if (ocnt_q == 2'd0 || pop) begin
        obuf_q[0] <= e0 ? r0 : r1;
        obuf_q[1] <= r1;
      end else begin
        obuf_q[1] <= e0 ? r0 : r1;
      end
    end else if (pop) begin
      obuf_q[0] <= obuf_q[1];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) ocnt_q != 2'd3)
    else $error("output buffer overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && job_i.eof) |=> (phase_q == crcp_pkg::PH_HEADER && fc_q == 8'd0))
    else $error("stream state not cleared after end of file");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == crcp_pkg::PH_PARAMS) |-> (fc_q < plen_q))
    else $error("parameter index beyond length");

endmodule
`default_nettype wire

>>> sv/crc_checked_script_record_parser_top.sv
// ----------------------------------------------------------------------------
// crc_checked_script_record_parser_top: checked script record parser
// Parses a CRC-16/XMODEM checked script file byte by byte into records.
// ----------------------------------------------------------------------------
// Usage: send file bytes on in_ch with end_of_file on the last byte. Each
// byte is held back two places so the trailing file CRC is never parsed.
// Step headers and parameter bytes appear on out_ch as records; the request
// carrying end_of_file yields a final status record (last_of_run set).
// Throughput: one request per cycle while out_ch is ready and each causes at
// most one record; a request that causes two (a record and the final status)
// stalls the parser while the two-slot output buffer drains.
// Path: a request's records pass the job queue, the parser and the output
// buffer before they are offered; a byte's own records come with the
// request two places later, as it leaves the front delay line.
// Registers on cfg_ch: 0 header magic, 1 step magic, 2 max steps; write
// only while idle. Reset clears all stream state and loads register
// defaults. When the receiver stalls, the output buffer fills, then the
// queue, then in_ch.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none
module crc_checked_script_record_parser_top #(
  parameter int unsigned MaxParamBytes = 64
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  crcp_in_if.sink   in_ch,
  crcp_cfg_if.sink  cfg_ch,
  crcp_out_if.source out_ch
);

  logic [31:0] hmagic_q, smagic_q;
  logic [15:0] maxs_q;
  logic        fj_valid, fj_ready, bj_valid, bj_ready, rv;
  crcp_pkg::job_t fj, bj;
  crcp_pkg::rec_t rec;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hmagic_q <= 32'hC0DE_DEAD;
      smagic_q <= '0;
      maxs_q   <= 16'd64;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        crcp_pkg::REG_HDR_MAGIC:  hmagic_q <= cfg_ch.data;
        crcp_pkg::REG_STEP_MAGIC: smagic_q <= cfg_ch.data;
        crcp_pkg::REG_MAX_STEPS:  maxs_q   <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  crcp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_data_i(in_ch.data_byte), .in_eof_i(in_ch.end_of_file),
    .in_ready_o(in_ch.ready), .job_valid_o(fj_valid), .job_o(fj), .job_ready_i(fj_ready)
  );

  crcp_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_job_i(fj), .wr_ready_o(fj_ready),
    .rd_valid_o(bj_valid), .rd_job_o(bj), .rd_ready_i(bj_ready)
  );

  crcp_back #(.MaxParamBytes(MaxParamBytes)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_i(bj), .job_ready_o(bj_ready),
    .hdr_magic_i(hmagic_q), .step_magic_i(smagic_q), .max_steps_i(maxs_q),
    .rec_valid_o(rv), .rec_o(rec), .rec_ready_i(out_ch.ready)
  );

  assign out_ch.valid          = rv;
  assign out_ch.record_kind    = rec.record_kind;
  assign out_ch.step_number    = rec.step_number;
  assign out_ch.step_ident     = rec.step_ident;
  assign out_ch.action_code    = rec.action_code;
  assign out_ch.param_length   = rec.param_length;
  assign out_ch.param_position = rec.param_position;
  assign out_ch.param_value    = rec.param_value;
  assign out_ch.parse_status   = rec.parse_status;
  assign out_ch.last_of_run    = rec.last_of_run;

endmodule
`default_nettype wire
